// File: hdl/affine_matrix_inverse_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_INVERSE_TOP_ASSERT_SVH
`define AFFINE_MATRIX_INVERSE_TOP_ASSERT_SVH

// same-cycle implication
`define AMX_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define AMX_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: hdl/amx_pkg.sv
// ----------------------------------------------------------------------------
// amx_pkg
// Types, constants and the multiply-accumulate step program of the affine
// 3x4 matrix inverse.
// ----------------------------------------------------------------------------
package amx_pkg;

   localparam int unsigned FRAC_BITS_DEF = 16;
   localparam int unsigned ELEM_W        = 32;
   localparam int unsigned CF_W          = 65;
   localparam int unsigned CF_LO_W       = 33;
   localparam int unsigned ACC_W         = 98;
   localparam int unsigned PROD_W        = 66;
   localparam int unsigned Q_W           = 32;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned COF_STEPS     = 18;
   localparam int unsigned TERM_STEPS    = 6;
   localparam int unsigned NUM_STEPS     = 42;
   localparam int unsigned STEP_W        = 6;

   typedef struct packed {
      logic signed [ELEM_W-1:0] r0_c0;
      logic signed [ELEM_W-1:0] r0_c1;
      logic signed [ELEM_W-1:0] r0_c2;
      logic signed [ELEM_W-1:0] r0_c3;
      logic signed [ELEM_W-1:0] r1_c0;
      logic signed [ELEM_W-1:0] r1_c1;
      logic signed [ELEM_W-1:0] r1_c2;
      logic signed [ELEM_W-1:0] r1_c3;
      logic signed [ELEM_W-1:0] r2_c0;
      logic signed [ELEM_W-1:0] r2_c1;
      logic signed [ELEM_W-1:0] r2_c2;
      logic signed [ELEM_W-1:0] r2_c3;
   } req_type;

   typedef struct packed {
      logic [1:0]            row_index;
      logic signed [Q_W-1:0] col0;
      logic signed [Q_W-1:0] col1;
      logic signed [Q_W-1:0] col2;
      logic signed [Q_W-1:0] col3;
      logic                  singular;
      logic                  last_row;
   } rsp_type;

   typedef enum logic [1:0] {SRC_ELEM, SRC_CF_LO, SRC_CF_HI} src_type;
   typedef enum logic [1:0] {DST_NONE, DST_CF, DST_DET, DST_TSUM} dst_type;

   typedef struct packed {
      src_type    a_src;
      logic [3:0] a_idx;
      logic [3:0] b_idx;
      logic       hi;
      logic       sub;
      logic       first;
      dst_type    dst;
      logic [3:0] dst_idx;
   } uop_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MAC, BK_DRAIN, BK_DIV_START, BK_DIV_WAIT, BK_ROW
   } back_state_type;

   typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_ITER, DV_DONE} div_state_type;

   typedef struct packed {
      logic                    start;
      logic                    lin;
      logic signed [ACC_W-1:0] num;
      logic signed [ACC_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [Q_W-1:0] q;
   } div_rsp_type;

   // adjugate entry k = e[a]*e[b] - e[c]*e[d]
   localparam logic [3:0] COF_TAB [9][4] = '{
      '{4'd5, 4'd10, 4'd9, 4'd6}, '{4'd9, 4'd2, 4'd1, 4'd10}, '{4'd1, 4'd6, 4'd5, 4'd2},
      '{4'd8, 4'd6, 4'd4, 4'd10}, '{4'd0, 4'd10, 4'd8, 4'd2}, '{4'd4, 4'd2, 4'd0, 4'd6},
      '{4'd4, 4'd9, 4'd8, 4'd5}, '{4'd8, 4'd1, 4'd0, 4'd9}, '{4'd0, 4'd5, 4'd4, 4'd1}
   };

   // steps 0..17: adjugate; then determinant, then the three translation sums,
   // each as three adjugate*element terms split into low and high halves
   function automatic uop_type step_uop(input logic [STEP_W-1:0] s);
      uop_type             u;
      logic [STEP_W-1:0]   t;
      logic [2:0]          w;
      logic [1:0]          grp;
      logic [1:0]          k;
      logic [3:0]          ci;
      u = '0;
      t = '0;
      w = '0;
      grp = '0;
      if (s < STEP_W'(COF_STEPS)) begin
         ci = 4'(s >> 1);
         u.a_src = SRC_ELEM;
         if (s[0]) begin
            u.a_idx   = COF_TAB[ci][2];
            u.b_idx   = COF_TAB[ci][3];
            u.sub     = 1'b1;
            u.dst     = DST_CF;
            u.dst_idx = ci;
         end else begin
            u.a_idx = COF_TAB[ci][0];
            u.b_idx = COF_TAB[ci][1];
            u.first = 1'b1;
         end
      end else begin
         t = s - STEP_W'(COF_STEPS);
         priority if (t < STEP_W'(TERM_STEPS)) begin
            grp = 2'd0;
            w   = 3'(t);
         end else if (t < STEP_W'(2 * TERM_STEPS)) begin
            grp = 2'd1;
            w   = 3'(t - STEP_W'(TERM_STEPS));
         end else if (t < STEP_W'(3 * TERM_STEPS)) begin
            grp = 2'd2;
            w   = 3'(t - STEP_W'(2 * TERM_STEPS));
         end else begin
            grp = 2'd3;
            w   = 3'(t - STEP_W'(3 * TERM_STEPS));
         end
         k       = w[2:1];
         u.hi    = w[0];
         u.a_src = w[0] ? SRC_CF_HI : SRC_CF_LO;
         u.first = (w == 3'd0);
         if (grp == 2'd0) begin
            u.a_idx = 4'(k);
            u.b_idx = {k, 2'b00};
            u.dst   = (w == 3'(TERM_STEPS - 1)) ? DST_DET : DST_NONE;
         end else begin
            u.a_idx   = 4'(grp - 2'd1) * 4'd3 + 4'(k);
            u.b_idx   = {k, 2'b11};
            u.sub     = 1'b1;
            u.dst     = (w == 3'(TERM_STEPS - 1)) ? DST_TSUM : DST_NONE;
            u.dst_idx = 4'(grp - 2'd1);
         end
      end
      return u;
   endfunction

endpackage

// File: hdl/amx_queue.sv
// ----------------------------------------------------------------------------
// amx_queue
// Front end: accepts matrix items and holds them until the back end is free.
// ----------------------------------------------------------------------------
module amx_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  amx_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output amx_pkg::req_type out_data
);
   import amx_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               push;
   logic               pop;

   assign in_ready  = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// File: hdl/amx_div.sv
// ----------------------------------------------------------------------------
// amx_div
// Signed fixed-point divider: num * 2^shift / den, truncated toward zero,
// saturated to 32 bits. Overflow check, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "affine_matrix_inverse_top_assert.svh"

module amx_div #(
   parameter int unsigned FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  amx_pkg::div_req_type req,
   output amx_pkg::div_rsp_type rsp
);
   import amx_pkg::*;

   localparam int unsigned DIV_W = ACC_W + 2 * FRAC_BITS + 2;
   localparam int unsigned CNT_W = $clog2(Q_W);

   div_state_type     state_ff;
   div_state_type     state_in;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  ds_ff;
   logic [Q_W-1:0]    q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff;
   logic              ovf_ff;
   logic [ACC_W-1:0]  num_mag;
   logic [ACC_W-1:0]  den_mag;
   logic              ovf;
   logic              ge;
   logic [Q_W-1:0]    q_out;

   assign num_mag = req.num[ACC_W-1] ? ACC_W'(-req.num) : ACC_W'(req.num);
   assign den_mag = req.den[ACC_W-1] ? ACC_W'(-req.den) : ACC_W'(req.den);
   assign ovf     = (rem_ff >= (ds_ff << 1));
   assign ge      = (rem_ff >= ds_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DV_IDLE:  if (req.start) state_in = DV_CHECK;
         DV_CHECK: state_in = ovf ? DV_DONE : DV_ITER;
         DV_ITER:  if (cnt_ff == '0) state_in = DV_DONE;
         DV_DONE:  state_in = DV_IDLE;
         default:  state_in = DV_IDLE;
      endcase
   end

   always_comb begin
      if (!neg_ff) begin
         q_out = (ovf_ff || q_ff[Q_W-1]) ? {1'b0, {(Q_W-1){1'b1}}} : q_ff;
      end else begin
         q_out = (ovf_ff || (q_ff > {1'b1, {(Q_W-1){1'b0}}})) ?
                 {1'b1, {(Q_W-1){1'b0}}} : (~q_ff + 1'b1);
      end
      rsp.done = (state_ff == DV_DONE);
      rsp.q    = q_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      unique case (state_ff)
         DV_IDLE: begin
            if (req.start) begin
               rem_ff <= DIV_W'(num_mag) << (req.lin ? 2 * FRAC_BITS : FRAC_BITS);
               ds_ff  <= DIV_W'(den_mag) << (Q_W - 1);
               neg_ff <= req.num[ACC_W-1] ^ req.den[ACC_W-1];
               q_ff   <= '0;
               cnt_ff <= CNT_W'(Q_W - 1);
               ovf_ff <= 1'b0;
            end
         end
         DV_CHECK: begin
            ovf_ff <= ovf;
         end
         DV_ITER: begin
            if (ge) begin
               rem_ff <= rem_ff - ds_ff;
            end
            q_ff   <= {q_ff[Q_W-2:0], ge};
            ds_ff  <= ds_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   `AMX_ASSERT_IMP(a_div_start_idle, req.start, state_ff == DV_IDLE, "divider started while busy")
   `AMX_ASSERT_IMP(a_div_rem_bound, state_ff == DV_ITER, rem_ff < (ds_ff << 1), "remainder out of range")
   `AMX_ASSERT_IMP(a_div_pos_sat, rsp.done && ovf_ff && !neg_ff, rsp.q == 32'sh7FFFFFFF, "bad saturation")

endmodule

// File: hdl/amx_back.sv
// ----------------------------------------------------------------------------
// amx_back
// Back end: shared multiplier and accumulator step through adjugate,
// determinant and translation sums; the divider forms each nonsingular result.
// ----------------------------------------------------------------------------
`include "affine_matrix_inverse_top_assert.svh"

module amx_back #(
   parameter int unsigned FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  amx_pkg::req_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output amx_pkg::rsp_type rsp_data
);
   import amx_pkg::*;

   back_state_type            state_ff;
   back_state_type            state_in;
   logic signed [ELEM_W-1:0]  e_ff [12];
   logic signed [CF_W-1:0]    cf_ff [9];
   logic signed [ACC_W-1:0]   det_ff;
   logic signed [ACC_W-1:0]   ts_ff [3];
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   term;
   logic [STEP_W-1:0]         step_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic                      prod_vld_ff;
   uop_type                   puop_ff;
   uop_type                   uop;
   logic signed [CF_LO_W:0]   a_op;
   logic signed [ELEM_W-1:0]  b_op;
   logic [1:0]                qrow_ff;
   logic [1:0]                qcol_ff;
   logic [3:0]                cf_idx;
   logic signed [Q_W-1:0]     row_ff [4];
   logic                      rsp_vld_ff;
   rsp_type                   rsp_ff;
   logic                      sing;
   logic                      out_free;
   logic                      load;
   logic                      issue;
   logic                      col_store;
   logic                      row_load;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   amx_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign sing     = (det_ff == '0);
   assign out_free = !rsp_vld_ff || rsp_ready;
   assign uop      = step_uop(step_ff);

   always_comb begin
      unique case (uop.a_src)
         SRC_ELEM:  a_op = {{2{e_ff[uop.a_idx][ELEM_W-1]}}, e_ff[uop.a_idx]};
         SRC_CF_LO: a_op = {1'b0, cf_ff[uop.a_idx][CF_LO_W-1:0]};
         SRC_CF_HI: a_op = {{2{cf_ff[uop.a_idx][CF_W-1]}},
                            cf_ff[uop.a_idx][CF_W-1:CF_LO_W]};
         default:   a_op = '0;
      endcase
      b_op    = e_ff[uop.b_idx];
      prod_in = a_op * b_op;
   end

   always_comb begin
      term = puop_ff.hi ? (ACC_W'(prod_ff) <<< CF_LO_W) : ACC_W'(prod_ff);
      if (puop_ff.sub) begin
         term = -term;
      end
      acc_in = puop_ff.first ? term : acc_ff + term;
   end

   always_comb begin
      cf_idx = (qcol_ff == 2'd3) ? 4'd0 : 4'(qrow_ff) * 4'd3 + 4'(qcol_ff);
      div_req.start = (state_ff == BK_DIV_START) && !sing;
      div_req.lin = (qcol_ff != 2'd3);
      div_req.num = (qcol_ff == 2'd3) ? ts_ff[qrow_ff] : ACC_W'(cf_ff[cf_idx]);
      div_req.den = det_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:      if (in_valid) state_in = BK_MAC;
         BK_MAC:       if (step_ff == STEP_W'(NUM_STEPS - 1)) state_in = BK_DRAIN;
         BK_DRAIN:     state_in = BK_DIV_START;
         BK_DIV_START: begin
            if (!sing) state_in = BK_DIV_WAIT;
            else if (qcol_ff == 2'd3) state_in = BK_ROW;
         end
         BK_DIV_WAIT:  begin
            if (div_rsp.done) state_in = (qcol_ff == 2'd3) ? BK_ROW : BK_DIV_START;
         end
         BK_ROW:       begin
            if (out_free) state_in = (qrow_ff == 2'd2) ? BK_IDLE : BK_DIV_START;
         end
         default:      state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      in_ready      = (state_ff == BK_IDLE);
      load          = in_ready && in_valid;
      issue         = (state_ff == BK_MAC);
      col_store     = ((state_ff == BK_DIV_START) && sing) ||
                      ((state_ff == BK_DIV_WAIT) && div_rsp.done);
      row_load      = (state_ff == BK_ROW) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= issue;
         if (row_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      if (load) begin
         e_ff[0]  <= in_data.r0_c0;
         e_ff[1]  <= in_data.r0_c1;
         e_ff[2]  <= in_data.r0_c2;
         e_ff[3]  <= in_data.r0_c3;
         e_ff[4]  <= in_data.r1_c0;
         e_ff[5]  <= in_data.r1_c1;
         e_ff[6]  <= in_data.r1_c2;
         e_ff[7]  <= in_data.r1_c3;
         e_ff[8]  <= in_data.r2_c0;
         e_ff[9]  <= in_data.r2_c1;
         e_ff[10] <= in_data.r2_c2;
         e_ff[11] <= in_data.r2_c3;
         step_ff  <= '0;
         qrow_ff  <= '0;
         qcol_ff  <= '0;
      end
      if (issue) begin
         prod_ff <= prod_in;
         puop_ff <= uop;
         step_ff <= step_ff + 1'b1;
      end
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
         unique case (puop_ff.dst)
            DST_CF:   cf_ff[puop_ff.dst_idx] <= acc_in[CF_W-1:0];
            DST_DET:  det_ff <= acc_in;
            DST_TSUM: ts_ff[puop_ff.dst_idx[1:0]] <= acc_in;
            default:  begin
            end
         endcase
      end
      if (col_store) begin
         row_ff[qcol_ff] <= sing ? '0 : div_rsp.q;
         qcol_ff         <= qcol_ff + 1'b1;
      end
      if (row_load) begin
         rsp_ff.row_index <= qrow_ff;
         rsp_ff.col0      <= row_ff[0];
         rsp_ff.col1      <= row_ff[1];
         rsp_ff.col2      <= row_ff[2];
         rsp_ff.col3      <= row_ff[3];
         rsp_ff.singular  <= sing;
         rsp_ff.last_row  <= (qrow_ff == 2'd2);
         qrow_ff          <= qrow_ff + 1'b1;
         qcol_ff          <= '0;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `AMX_ASSERT_IMP(a_bk_last_row, rsp_vld_ff,
      rsp_ff.last_row == (rsp_ff.row_index == 2'd2), "last_row mismatch")
   `AMX_ASSERT_IMP(a_bk_sing_zero, rsp_vld_ff && rsp_ff.singular,
      (rsp_ff.col0 == '0) && (rsp_ff.col1 == '0) && (rsp_ff.col2 == '0) &&
      (rsp_ff.col3 == '0), "singular row not zero")
   `AMX_ASSERT_IMP(a_bk_step_range, state_ff == BK_MAC,
      step_ff < STEP_W'(NUM_STEPS), "step out of range")

endmodule

// File: hdl/affine_matrix_inverse_top.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse_top
// Inverts a 3x4 affine transform of signed fixed-point words and returns
// its three rows, or three zero rows flagged singular.
// In the back end, the shared 34x32 multiplier steps through adjugate,
// determinant and translation sums, then twelve quotients go through the
// single radix-2 divider. A two-item queue takes new matrices while one
// is being worked on, and the result register lets the next row be
// computed while the current one waits.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_top #(
   parameter int unsigned FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  amx_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output amx_pkg::rsp_type rsp_payload
);
   import amx_pkg::*;

   logic    q_valid;
   logic    q_ready;
   req_type q_data;

   amx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   amx_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_payload)
   );

endmodule
